// ===== design/cpc_pkg.sv =====
package cpc_pkg;

	// Fraction bits of the internal coordinates
	localparam int FRAC = 16;

	// Angle accumulator width, units of 2^-32 turn with headroom
	localparam int ZW = 34;

	// Longest supported chain of cells
	localparam int TABLE_LEN = 24;

	// Gain compensation, Q30: KG_INF + (KG_TAIL >> (2 * iterations))
	localparam int unsigned KG_INF  = 32'd652032874;
	localparam int unsigned KG_TAIL = 32'd434688582;

	// Turn fractions in accumulator units
	localparam logic signed [ZW-1:0] HALF_TURN = 34'sh0_8000_0000;

	// Angle codes in binary units, 65536 per turn
	localparam logic signed [16:0] ANG_QUARTER = 17'sd16384;
	localparam logic signed [16:0] ANG_HALF    = 17'sd32768;

	// Command codes
	localparam logic CMD_TO_POLAR = 1'b0;
	localparam logic CMD_TO_CART  = 1'b1;

	// round(atan(2^-i) * 2^32 / (2*pi))
	localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Control that travels with each item down the chain
	typedef struct packed {
		logic vld;
		logic rot;
		logic zero;
	} ctl_t;

endpackage

// ===== design/cpc_entry.sv =====
module cpc_entry #(
	parameter int COORD_WIDTH = 16,
	parameter int W = 34,
	parameter logic [30:0] KG = 31'd652032874
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic                          cmd,
	input  logic signed [COORD_WIDTH-1:0] in_first,
	input  logic signed [COORD_WIDTH-1:0] in_second,
	output cpc_pkg::ctl_t                 ctl_o,
	output logic signed [W-1:0]           x_o,
	output logic signed [W-1:0]           y_o,
	output logic signed [cpc_pkg::ZW-1:0] z_o
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = CW + 32;
	localparam int AW = (CW > 16) ? CW : 16;
	localparam int ZW = cpc_pkg::ZW;
	localparam logic signed [31:0] KG_S = 32'(KG);

	logic signed [PW-1:0] prod_a, prod_b;
	logic [AW-1:0]        sec_ext;

	cpc_pkg::ctl_t        ctl_s1;
	logic signed [PW-1:0] prod_a_s1, prod_b_s1;
	logic [15:0]          ang_s1;
	logic                 neg_s1;

	logic signed [W-1:0]  xs, ys;
	logic signed [16:0]   ang_w, ang_red;
	logic                 ang_gt, ang_lt;
	logic signed [ZW-1:0] z_rot;

	// Scale both coordinates by the gain
	assign prod_a  = PW'(in_first) * PW'(KG_S);
	assign prod_b  = PW'(in_second) * PW'(KG_S);
	assign sec_ext = AW'($unsigned(in_second));

	// Stage 1: register products and item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld  <= vld_in;
			ctl_s1.rot  <= cmd;
			ctl_s1.zero <= (cmd == cpc_pkg::CMD_TO_POLAR) && (in_first == '0) &&
				(in_second == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1 <= prod_a;
			prod_b_s1 <= prod_b;
			ang_s1    <= sec_ext[15:0];
			neg_s1    <= in_first[CW-1];
		end
	end

	// Drop the fraction excess, reduce the angle to within a quarter turn
	always_comb begin
		xs      = W'(prod_a_s1 >>> 14);
		ys      = W'(prod_b_s1 >>> 14);
		ang_w   = 17'(signed'(ang_s1));
		ang_gt  = ang_w > cpc_pkg::ANG_QUARTER;
		ang_lt  = ang_w < -cpc_pkg::ANG_QUARTER;
		ang_red = ang_w;
		if (ang_gt) begin
			ang_red = ang_w - cpc_pkg::ANG_HALF;
		end else if (ang_lt) begin
			ang_red = ang_w + cpc_pkg::ANG_HALF;
		end
		z_rot = ZW'(ang_red) <<< 16;
	end

	// Stage 2: start vector and angle for the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s1.rot == cpc_pkg::CMD_TO_CART) begin
				x_o <= (ang_gt || ang_lt) ? -xs : xs;
				y_o <= '0;
				z_o <= z_rot;
			end else if (neg_s1) begin
				x_o <= -xs;
				y_o <= -ys;
				z_o <= cpc_pkg::HALF_TURN;
			end else begin
				x_o <= xs;
				y_o <= ys;
				z_o <= '0;
			end
		end
	end

endmodule

// ===== design/cpc_cell.sv =====
module cpc_cell #(
	parameter int W = 34,
	parameter int STEP = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  cpc_pkg::ctl_t                 ctl_i,
	input  logic signed [W-1:0]           x_i,
	input  logic signed [W-1:0]           y_i,
	input  logic signed [cpc_pkg::ZW-1:0] z_i,
	output cpc_pkg::ctl_t                 ctl_o,
	output logic signed [W-1:0]           x_o,
	output logic signed [W-1:0]           y_o,
	output logic signed [cpc_pkg::ZW-1:0] z_o
);

	localparam int ZW = cpc_pkg::ZW;
	localparam logic signed [ZW-1:0] ANG = ZW'(cpc_pkg::ATAN_TAB[STEP]);

	logic signed [W-1:0] tx, ty;
	logic                ccw;

	// Shifted copies round toward minus infinity
	assign tx = x_i >>> STEP;
	assign ty = y_i >>> STEP;

	// Rotation mode drives z to zero, vectoring mode drives y to zero
	assign ccw = ctl_i.rot ? ~z_i[ZW-1] : y_i[W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	// One micro-rotation, handed to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				x_o <= x_i - ty;
				y_o <= y_i + tx;
				z_o <= z_i - ANG;
			end else begin
				x_o <= x_i + ty;
				y_o <= y_i - tx;
				z_o <= z_i + ANG;
			end
		end
	end

endmodule

// ===== design/cpc_out.sv =====
module cpc_out #(
	parameter int COORD_WIDTH = 16,
	parameter int W = 34,
	parameter int DW = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  cpc_pkg::ctl_t                 ctl_i,
	input  logic signed [W-1:0]           x_i,
	input  logic signed [W-1:0]           y_i,
	input  logic signed [cpc_pkg::ZW-1:0] z_i,
	output logic                          room,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [DW-1:0]                 m_tdata
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = (CW > 16) ? CW : 16;
	localparam int ZW = cpc_pkg::ZW;
	localparam int EW = 2 * CW + 1;
	localparam logic [1:0] FULL = 2'd2;
	localparam logic signed [W:0] RND = (W + 1)'(1 << (cpc_pkg::FRAC - 1));
	localparam logic signed [ZW-1:0] ZRND = ZW'(1 << (cpc_pkg::FRAC - 1));
	localparam logic [CW-1:0] Y_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] Y_MIN = {1'b1, {(CW - 1){1'b0}}};

	logic signed [W:0]    rx, ry;
	logic signed [ZW-1:0] z_sum;
	logic signed [AW-1:0] ang_ext;
	logic [W-CW+1:0]      ry_top;
	logic [CW-1:0]        y_sat;
	logic [CW:0]          first_f;
	logic [CW-1:0]        second_f;
	logic [EW-1:0]        entry;

	logic [EW-1:0] mem_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    count_q;
	logic          push, pop;

	// Round coordinates to integers, fold the angle to binary units
	always_comb begin
		rx      = ((W + 1)'(x_i) + RND) >>> cpc_pkg::FRAC;
		ry      = ((W + 1)'(y_i) + RND) >>> cpc_pkg::FRAC;
		z_sum   = z_i + ZRND;
		ang_ext = AW'(signed'(z_sum[31:16]));
		ry_top  = ry[W:CW-1];
		if (ry_top == '0 || ry_top == '1) begin
			y_sat = ry[CW-1:0];
		end else begin
			y_sat = ry[W] ? Y_MIN : Y_MAX;
		end
		if (ctl_i.rot == cpc_pkg::CMD_TO_CART) begin
			first_f  = rx[CW:0];
			second_f = y_sat;
		end else if (ctl_i.zero) begin
			first_f  = '0;
			second_f = '0;
		end else begin
			first_f  = rx[CW:0];
			second_f = ang_ext[CW-1:0];
		end
		entry = {second_f, first_f};
	end

	assign push     = en && ctl_i.vld;
	assign pop      = m_tvalid && m_tready;
	assign room     = count_q != FULL;
	assign m_tvalid = count_q != 2'd0;
	assign m_tdata  = DW'(mem_q[rd_q]);

	// Two-entry skid queue between the chain and the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= entry;
		end
	end

endmodule

// ===== design/cartesian_polar_converter.sv =====
// Cartesian/polar converter built as a chain of CORDIC cells.
// Input transaction (s_*): s_tuser carries the command, 0 converts (x, y) to
// magnitude and angle, 1 converts magnitude and angle to (x, y). s_tdata holds
// the first operand (x or magnitude) in the low COORD_WIDTH bits and the second
// (y or angle) above it. Angles are binary units, 65536 per turn.
// Output transaction (m_*): m_tdata holds magnitude or x (COORD_WIDTH+1 bits)
// low, and the angle or y (COORD_WIDTH bits) above it.
// From input to m_tvalid the item passes two entry stages (gain multiply,
// quadrant fold), one cell per iteration, and the output queue write.
// Throughput: one transaction per cycle while the output queue has room; every
// cell takes a new item each cycle unless the full queue holds the chain.
// Reset clears all valid flags and the output queue; s_tready is high after it.
// When the receiver stalls, results collect in a two-entry output queue; once
// it is full the whole chain holds and s_tready drops until m_tready returns.
module cartesian_polar_converter #(
	parameter int ITERATIONS = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// in_first, in_second
	input  logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// cmd
	input  logic [0:0]                              s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// out_first, out_second
	output logic [((2 * COORD_WIDTH + 8) / 8) * 8 - 1:0] m_tdata
);

	localparam int CW = COORD_WIDTH;
	localparam int W = CW + 18;
	localparam int ZW = cpc_pkg::ZW;
	localparam int DWO = ((2 * CW + 8) / 8) * 8;
	localparam logic [30:0] KG = 31'(cpc_pkg::KG_INF +
		(cpc_pkg::KG_TAIL >> (2 * ITERATIONS)));

	logic en;

	cpc_pkg::ctl_t        ctl_c [ITERATIONS+1];
	logic signed [W-1:0]  x_c   [ITERATIONS+1];
	logic signed [W-1:0]  y_c   [ITERATIONS+1];
	logic signed [ZW-1:0] z_c   [ITERATIONS+1];

	// Advance the whole chain while the output queue has space
	assign s_tready = en;

	cpc_entry #(
		.COORD_WIDTH(CW),
		.W(W),
		.KG(KG)
	) u_entry (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(s_tvalid),
		.cmd(s_tuser[0]),
		.in_first(signed'(s_tdata[CW-1:0])),
		.in_second(signed'(s_tdata[2*CW-1:CW])),
		.ctl_o(ctl_c[0]),
		.x_o(x_c[0]),
		.y_o(y_c[0]),
		.z_o(z_c[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		cpc_cell #(
			.W(W),
			.STEP(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.ctl_i(ctl_c[i]),
			.x_i(x_c[i]),
			.y_i(y_c[i]),
			.z_i(z_c[i]),
			.ctl_o(ctl_c[i+1]),
			.x_o(x_c[i+1]),
			.y_o(y_c[i+1]),
			.z_o(z_c[i+1])
		);
	end

	cpc_out #(
		.COORD_WIDTH(CW),
		.W(W),
		.DW(DWO)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.ctl_i(ctl_c[ITERATIONS]),
		.x_i(x_c[ITERATIONS]),
		.y_i(y_c[ITERATIONS]),
		.z_i(z_c[ITERATIONS]),
		.room(en),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ===== design/cpc_chk.sv =====
module cpc_chk #(
	parameter int COORD_WIDTH = 16
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    s_tvalid,
	input logic                                    s_tready,
	input logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	input logic [0:0]                              s_tuser,
	input logic                                    m_tvalid,
	input logic                                    m_tready,
	input logic [((2 * COORD_WIDTH + 8) / 8) * 8 - 1:0] m_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// Input stalls only behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// Queue fills only after the receiver refused a result
	a_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without a refused result");

endmodule

bind cartesian_polar_converter cpc_chk #(
	.COORD_WIDTH(COORD_WIDTH)
) u_cpc_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata(s_tdata),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITERS = 16;
	localparam int LATENCY = ITERS + 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam longint GAIN_Q30 = 64'sd652032874 + (64'sd434688582 >>> (2 * ITERS));
	localparam longint TURN_HALF = 64'sd2147483648;
	localparam longint TURN_QUARTER = 64'sd1073741824;
	localparam logic signed [15:0] C_MAX = 16'sh7fff;
	localparam logic signed [15:0] C_MIN = 16'sh8000;

	// Arctangent of 2^-i in units of 2^-32 turn
	localparam longint ATAN_STEP [ITERS] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10680094, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};

	typedef struct {
		logic        cmd;
		logic [16:0] first;
		logic [15:0] second;
	} conv_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	conv_result_t pending_results[$];
	int mismatches = 0;
	int cycle_count = 0;
	int sent_polar = 0;
	int sent_cart = 0;
	int checked_results = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	cartesian_polar_converter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Compute the CORDIC result of one transaction
	function automatic conv_result_t cordic_convert(input logic cmd,
			input logic signed [15:0] first, input logic signed [15:0] second);
		conv_result_t res;
		longint a, b, x, y, z, tx, ty, rx, ry;
		a = first;
		b = second;
		res.cmd = cmd;
		if (cmd == cpc_pkg::CMD_TO_POLAR) begin
			if (a == 0 && b == 0) begin
				res.first = '0;
				res.second = '0;
				return res;
			end
			x = (a * GAIN_Q30) >>> (30 - cpc_pkg::FRAC);
			y = (b * GAIN_Q30) >>> (30 - cpc_pkg::FRAC);
			z = 0;
			// Fold the left half plane onto the right
			if (a < 0) begin
				x = -x;
				y = -y;
				z = TURN_HALF;
			end
			for (int i = 0; i < ITERS; i++) begin
				tx = x >>> i;
				ty = y >>> i;
				if (y < 0) begin
					x = x - ty;
					y = y + tx;
					z = z - ATAN_STEP[i];
				end else begin
					x = x + ty;
					y = y - tx;
					z = z + ATAN_STEP[i];
				end
			end
			rx = (x + 64'sd32768) >>> cpc_pkg::FRAC;
			res.first = rx[16:0];
			z = (z + 64'sd32768) >>> 16;
			res.second = z[15:0];
		end else begin
			x = (a * GAIN_Q30) >>> (30 - cpc_pkg::FRAC);
			y = 0;
			z = b * 65536;
			// Bring the angle into the right half plane
			if (z > TURN_QUARTER) begin
				z = z - TURN_HALF;
				x = -x;
			end else if (z < -TURN_QUARTER) begin
				z = z + TURN_HALF;
				x = -x;
			end
			for (int i = 0; i < ITERS; i++) begin
				tx = x >>> i;
				ty = y >>> i;
				if (z >= 0) begin
					x = x - ty;
					y = y + tx;
					z = z - ATAN_STEP[i];
				end else begin
					x = x + ty;
					y = y - tx;
					z = z + ATAN_STEP[i];
				end
			end
			rx = (x + 64'sd32768) >>> cpc_pkg::FRAC;
			ry = (y + 64'sd32768) >>> cpc_pkg::FRAC;
			// Saturate y to the coordinate range
			if (ry > 32767)
				ry = 32767;
			if (ry < -32768)
				ry = -32768;
			res.first = rx[16:0];
			res.second = ry[15:0];
		end
		return res;
	endfunction

	// Pick a coordinate, biased toward the extremes and the values around zero
	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 11))
			0: return C_MAX;
			1: return C_MIN;
			2: return 16'd0;
			3: return 16'hffff;
			4: return 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// Drive one transaction and hold it until accepted
	task automatic send_item(input logic cmd, input logic [15:0] first,
			input logic [15:0] second);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {second, first};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(cordic_convert(cmd, first, second));
		if (cmd == cpc_pkg::CMD_TO_POLAR)
			sent_polar++;
		else
			sent_cart++;
	endtask

	// Hold the input idle until every outstanding result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_polar_directed();
		send_item(cpc_pkg::CMD_TO_POLAR, 16'd0, 16'd0);
		send_item(cpc_pkg::CMD_TO_POLAR, C_MAX, 16'd0);
		send_item(cpc_pkg::CMD_TO_POLAR, C_MIN, 16'd0);
		send_item(cpc_pkg::CMD_TO_POLAR, 16'hffff, 16'd0);
		send_item(cpc_pkg::CMD_TO_POLAR, 16'd0, C_MAX);
		send_item(cpc_pkg::CMD_TO_POLAR, 16'd0, C_MIN);
		send_item(cpc_pkg::CMD_TO_POLAR, C_MAX, C_MAX);
		send_item(cpc_pkg::CMD_TO_POLAR, C_MIN, C_MIN);
		send_item(cpc_pkg::CMD_TO_POLAR, C_MIN, C_MAX);
		send_item(cpc_pkg::CMD_TO_POLAR, C_MAX, C_MIN);
		send_item(cpc_pkg::CMD_TO_POLAR, 16'd1, 16'd1);
		send_item(cpc_pkg::CMD_TO_POLAR, -16'sd5, 16'd3);
	endtask

	task automatic test_cart_directed();
		send_item(cpc_pkg::CMD_TO_CART, C_MAX, 16'd0);
		send_item(cpc_pkg::CMD_TO_CART, C_MAX, 16'd16384);
		send_item(cpc_pkg::CMD_TO_CART, C_MAX, -16'sd16384);
		send_item(cpc_pkg::CMD_TO_CART, C_MAX, C_MIN);
		send_item(cpc_pkg::CMD_TO_CART, C_MIN, 16'd16384);
		send_item(cpc_pkg::CMD_TO_CART, C_MIN, -16'sd16384);
		send_item(cpc_pkg::CMD_TO_CART, C_MIN, C_MAX);
		send_item(cpc_pkg::CMD_TO_CART, 16'd100, 16'd16385);
		send_item(cpc_pkg::CMD_TO_CART, 16'd100, -16'sd16385);
		send_item(cpc_pkg::CMD_TO_CART, 16'd0, 16'd1234);
		send_item(cpc_pkg::CMD_TO_CART, C_MIN, 16'd0);
		send_item(cpc_pkg::CMD_TO_CART, C_MAX, 16'd8192);
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++)
			send_item(1'($urandom), pick_coord(), pick_coord());
	endtask

	// Run back to back with both sides always ready
	task automatic test_streaming(input int count);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random(count);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Accept results and compare them with the oldest prediction
	initial begin
		conv_result_t want;
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = rx_idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: m_tdata=%h", m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				checked_results++;
				if (m_tdata[16:0] !== want.first) begin
					$error("out_first (cmd %0d): expected %0d, actual %0d", want.cmd,
						$signed(want.first), $signed(m_tdata[16:0]));
					mismatches++;
				end
				if (m_tdata[32:17] !== want.second) begin
					$error("out_second (cmd %0d): expected %0d, actual %0d", want.cmd,
						$signed(want.second), $signed(m_tdata[32:17]));
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_polar_directed();
		test_cart_directed();
		test_random(400);
		test_streaming(150);
		drain_results();
		test_random(450);
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d Cartesian-to-polar and %0d polar-to-Cartesian transactions,",
			sent_polar, sent_cart);
		$display("%0d results compared, %0d mismatches", checked_results, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
